@@ design/fap_pkg.sv @@
// Package: constants, octant table and rounding multiply helper for the atan2 pipeline.
package fap_pkg;

    localparam int unsigned DivSteps = 16;
    localparam int unsigned NStage   = 6;

    localparam logic [15:0] OneQ15     = 16'h8000;
    localparam logic [15:0] OneQ14     = 16'h4000;
    localparam logic [15:0] C0625Q18   = 16'd16384;
    localparam logic [15:0] C270519Q17 = 16'd35457;
    localparam logic [15:0] C299045Q16 = 16'd19598;
    localparam logic [15:0] C271553Q15 = 16'd8898;

    typedef struct packed {
        logic [2:0] oct;
        logic       neg;
    } t_oct_info;

    function automatic logic [7:0] octant_base(input logic [2:0] oct);
        case (oct)
            3'd0: octant_base = 8'h00;
            3'd1: octant_base = 8'h40;
            3'd2: octant_base = 8'h00;
            3'd3: octant_base = 8'hc0;
            3'd4: octant_base = 8'h80;
            3'd5: octant_base = 8'h40;
            3'd6: octant_base = 8'h80;
            default: octant_base = 8'hc0;
        endcase
    endfunction

    function automatic logic [15:0] round_mul16(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        p = 32'(a) * 32'(b) + 32'h8000;
        round_mul16 = p[31:16];
    endfunction

endpackage

@@ design/fap_fold.sv @@
// Fold stage: saturate, take absolute values, swap into the first octant.
module fap_fold (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [15:0]          i_y,
    input  logic [15:0]          i_x,
    output logic                 o_valid,
    output logic [15:0]          o_num,
    output logic [15:0]          o_den,
    output fap_pkg::t_oct_info   o_info
);
    import fap_pkg::*;

    logic [15:0] n_ay, n_ax;
    logic [2:0]  n_oct;
    logic [15:0] r_num, r_den;
    t_oct_info   r_info;
    logic        r_valid;

    always_comb begin
        logic [15:0] y, x;
        y = (i_y == 16'h8000) ? 16'h8001 : i_y;
        x = (i_x == 16'h8000) ? 16'h8001 : i_x;
        n_oct = 3'd0;
        n_ax = x;
        n_ay = y;
        if (x[15]) begin
            n_ax = 16'd0 - x;
            n_oct[2] = 1'b1;
        end
        if (y[15]) begin
            n_ay = 16'd0 - y;
            n_oct[1] = 1'b1;
        end
        if (n_ay > n_ax) begin
            {n_ax, n_ay} = {n_ay, n_ax};
            n_oct[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_num       <= n_ay;
            r_den       <= n_ax;
            r_info.oct  <= n_oct;
            r_info.neg  <= ^n_oct;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_info  = r_info;
endmodule

@@ design/fap_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, (num<<15)/den.
module fap_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [15:0]          i_num,
    input  logic [15:0]          i_den,
    input  fap_pkg::t_oct_info   i_info,
    output logic                 o_valid,
    output logic [15:0]          o_ratio,
    output fap_pkg::t_oct_info   o_info
);
    import fap_pkg::*;

    // num <= den so quotient of (num<<15)/den fits 16 bits; remainder < den.
    logic [DivSteps:1]      r_valid;
    logic [16:0]            r_rem  [1:DivSteps];
    logic [15:0]            r_quo  [1:DivSteps];
    logic [15:0]            r_den  [1:DivSteps];
    t_oct_info              r_info [1:DivSteps];

    for (genvar s = 0; s < DivSteps; s++) begin : g_step
        logic        c_valid;
        logic [16:0] c_rem;
        logic [15:0] c_quo;
        logic [15:0] c_den;
        t_oct_info   c_info;
        logic [16:0] n_rem;
        logic        n_bit;
        if (s == 0) begin : g_head
            assign c_valid = i_valid;
            assign c_rem   = 17'(i_num);
            assign c_quo   = 16'd0;
            assign c_den   = i_den;
            assign c_info  = i_info;
        end else begin : g_body
            assign c_valid = r_valid[s];
            assign c_rem   = r_rem[s];
            assign c_quo   = r_quo[s];
            assign c_den   = r_den[s];
            assign c_info  = r_info[s];
        end
        // Step s decides quotient bit (15-s).
        assign n_bit = (c_den != 16'd0) && (c_rem >= 17'(c_den));
        assign n_rem = n_bit ? c_rem - 17'(c_den) : c_rem;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[s+1] <= c_valid;
            end
            if (i_en) begin
                r_rem[s+1]  <= {n_rem[15:0], 1'b0};
                r_quo[s+1]  <= {c_quo[14:0], n_bit};
                r_den[s+1]  <= c_den;
                r_info[s+1] <= c_info;
            end
        end
    end

    assign o_valid = r_valid[DivSteps];
    assign o_ratio = r_quo[DivSteps];
    assign o_info  = r_info[DivSteps];
endmodule

@@ design/fap_poly.sv @@
// Polynomial stages: Horner chain of rounding multiplies, sign and base angle.
module fap_poly (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [15:0]          i_ratio,
    input  fap_pkg::t_oct_info   i_info,
    output logic                 o_valid,
    output logic [15:0]          o_angle
);
    import fap_pkg::*;

    logic [NStage-1:0] r_valid;
    logic [15:0]       r_r    [NStage];
    logic [15:0]       r_s    [NStage];
    t_oct_info         r_info [NStage];
    logic [15:0]       n_s    [NStage];

    always_comb begin
        logic [15:0] hb;
        hb = {8'd0, i_ratio[15:8]} * {8'd0, C0625Q18[15:8]};
        n_s[0] = C270519Q17 - hb;
        n_s[1] = C299045Q16 - round_mul16(r_r[0], r_s[0]);
        n_s[2] = C271553Q15 + round_mul16(r_r[1], r_s[1]);
        n_s[3] = OneQ14 + round_mul16(OneQ15 - r_r[2], r_s[2]);
        n_s[4] = round_mul16(r_r[3], r_s[3]);
        n_s[5] = (r_info[4].neg ? 16'd0 - r_s[4] : r_s[4])
                 + {octant_base(r_info[4].oct), 8'h00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[NStage-2:0], i_valid};
        end
        if (i_en) begin
            r_r[0]    <= i_ratio;
            r_s[0]    <= n_s[0];
            r_info[0] <= i_info;
            for (int k = 1; k < NStage; k++) begin
                r_r[k]    <= r_r[k-1];
                r_s[k]    <= n_s[k];
                r_info[k] <= r_info[k-1];
            end
        end
    end

    assign o_valid = r_valid[NStage-1];
    assign o_angle = r_s[NStage-1];
endmodule

@@ design/fixed_atan2_octant_polynomial_top.sv @@
// Top level: streaming atan2 pipeline with global stall enable.
// One beat enters per cycle unless stalled. Stages: 1 fold, 16 divider
// stages at one quotient bit each, 6 polynomial. The whole pipeline
// advances whenever the output register is empty or being taken, so a stall
// on the master side holds every stage in place.
module fixed_atan2_octant_polynomial_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] y_value, [31:16] x_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] angle
);
    import fap_pkg::*;

    logic       en;
    logic       f_valid, d_valid;
    logic [15:0] f_num, f_den, d_ratio;
    t_oct_info  f_info, d_info;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    fap_fold u_fold (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_axis_tvalid),
        .i_y(s_axis_tdata[15:0]), .i_x(s_axis_tdata[31:16]),
        .o_valid(f_valid), .o_num(f_num), .o_den(f_den), .o_info(f_info)
    );

    fap_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(f_valid), .i_num(f_num), .i_den(f_den), .i_info(f_info),
        .o_valid(d_valid), .o_ratio(d_ratio), .o_info(d_info)
    );

    fap_poly u_poly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(d_valid), .i_ratio(d_ratio), .i_info(d_info),
        .o_valid(m_axis_tvalid), .o_angle(m_axis_tdata)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_valid |-> d_ratio <= 16'h8000)
        else $error("ratio out of range");
endmodule

@@ tb/fixed_atan2_octant_polynomial_top_tb.sv @@
// Testbench for the streaming atan2 block: directed table plus random pairs checked by a predictor.
module fixed_atan2_octant_polynomial_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fap_pkg::*;

    localparam int unsigned RandItems = 600;
    localparam int unsigned Latency = 1 + DivSteps + NStage;
    localparam int unsigned WatchLimit = 5000;
    localparam logic [15:0] NoAngle = 16'hxxxx;

    typedef struct packed {
        logic [15:0] y;
        logic [15:0] x;
        logic [15:0] angle;
        logic        known;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    logic [15:0] angle_q[$];
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;
    bit          stim_done = 1'b0;

    fixed_atan2_octant_polynomial_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [15:0] rmul(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        p = {16'd0, a} * {16'd0, b} + 32'h8000;
        return p[31:16];
    endfunction

    function automatic logic [15:0] predict_angle(input logic [15:0] ry, input logic [15:0] rx);
        int          y;
        int          x;
        int          t;
        logic [2:0]  oct;
        logic [15:0] r;
        logic [15:0] s;
        logic [15:0] hb;
        logic [31:0] num;
        y = $signed(ry);
        x = $signed(rx);
        oct = 3'd0;
        if (y < -32767) y = -32767;
        if (x < -32767) x = -32767;
        if (x < 0) begin
            x = -x;
            oct[2] = 1'b1;
        end
        if (y < 0) begin
            y = -y;
            oct[1] = 1'b1;
        end
        if (y > x) begin
            t = x;
            x = y;
            y = t;
            oct[0] = 1'b1;
        end
        num = 32'(y) << 15;
        r = (x == 0) ? 16'd0 : 16'(num / 32'(x));
        hb = 16'({8'd0, r[15:8]} * {8'd0, C0625Q18[15:8]});
        s = C270519Q17 - hb;
        s = C299045Q16 - rmul(r, s);
        s = C271553Q15 + rmul(r, s);
        s = OneQ14 + rmul(OneQ15 - r, s);
        s = rmul(r, s);
        if (^oct) s = 16'd0 - s;
        return s + {octant_base(oct), 8'd0};
    endfunction

    task automatic send_pair(input logic [15:0] y, input logic [15:0] x);
        s_axis_tdata <= {x, y};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        angle_q.push_back(predict_angle(y, x));
        @(negedge i_clk);
    endtask

    task automatic send_row(input t_row row);
        if (row.known && predict_angle(row.y, row.x) !== row.angle) begin
            $display("%0t table angle: expected %h actual %h", $time, row.angle,
                     predict_angle(row.y, row.x));
            errors++;
        end
        send_pair(row.y, row.x);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (angle_q.size() == 0) begin
                $display("%0t unexpected angle: expected none actual %h", $time, m_axis_tdata);
                errors++;
            end else begin
                if (m_axis_tdata !== angle_q[0]) begin
                    $display("%0t angle mismatch: expected %h actual %h", $time, angle_q[0],
                             m_axis_tdata);
                    errors++;
                end
                void'(angle_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (stim_done && angle_q.size() == 0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WatchLimit) begin
            $display("** fixed_atan2_octant_polynomial_top: FAILED **");
            $finish;
        end
    end

    initial begin : stall_gen
        int unsigned mode;
        forever begin
            @(negedge i_clk);
            mode = 32'(($time / 4000) % 4);
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ($urandom_range(0, 1) != 0);
                default: m_axis_tready <= (($time / 20) % 7 < 2);
            endcase
        end
    end

    t_row table_rows[] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1'b1},
        '{16'h0000, 16'h7fff, 16'h0000, 1'b1},
        '{16'h7fff, 16'h0000, 16'h4000, 1'b1},
        '{16'h0000, 16'h8001, NoAngle, 1'b0},
        '{16'h8001, 16'h0000, NoAngle, 1'b0},
        '{16'h8000, 16'h0000, NoAngle, 1'b0},
        '{16'h0000, 16'h8000, NoAngle, 1'b0},
        '{16'h8000, 16'h8000, NoAngle, 1'b0},
        '{16'h8000, 16'h8001, NoAngle, 1'b0},
        '{16'h7fff, 16'h7fff, NoAngle, 1'b0},
        '{16'h7fff, 16'h8000, NoAngle, 1'b0},
        '{16'h8000, 16'h7fff, NoAngle, 1'b0},
        '{16'h0001, 16'h7fff, NoAngle, 1'b0},
        '{16'h7fff, 16'h0001, NoAngle, 1'b0},
        '{16'hffff, 16'hffff, NoAngle, 1'b0},
        '{16'h0001, 16'hffff, NoAngle, 1'b0},
        '{16'hffff, 16'h0001, NoAngle, 1'b0},
        '{16'h1234, 16'h5678, NoAngle, 1'b0},
        '{16'h5678, 16'h1234, NoAngle, 1'b0},
        '{16'h5678, 16'hedcc, NoAngle, 1'b0},
        '{16'h1234, 16'ha988, NoAngle, 1'b0},
        '{16'hedcc, 16'ha988, NoAngle, 1'b0},
        '{16'ha988, 16'hedcc, NoAngle, 1'b0},
        '{16'ha988, 16'h1234, NoAngle, 1'b0},
        '{16'hedcc, 16'h5678, NoAngle, 1'b0}
    };

    initial begin : stim
        int unsigned sent;
        int unsigned burst;
        int unsigned settle;
        int unsigned gap;
        bit          drained;
        logic [15:0] y;
        logic [15:0] x;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (table_rows[i]) send_row(table_rows[i]);
        s_axis_tvalid <= 1'b0;
        while (angle_q.size() != 0) @(negedge i_clk);
        sent = 0;
        drained = 1'b0;
        while (sent < RandItems) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < RandItems) begin
                case ($urandom_range(0, 3))
                    0: begin
                        y = 16'($urandom_range(0, 15)) - 16'd8;
                        x = 16'($urandom_range(0, 15)) - 16'd8;
                    end
                    1: begin
                        y = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
                        x = 16'($urandom);
                        if ($urandom_range(0, 1) != 0) {y, x} = {x, y};
                    end
                    default: begin
                        y = 16'($urandom);
                        x = 16'($urandom);
                    end
                endcase
                send_pair(y, x);
                burst--;
                sent++;
            end
            gap = $urandom_range(0, 6);
            if (!drained && sent >= RandItems / 2) begin
                drained = 1'b1;
                s_axis_tvalid <= 1'b0;
                do @(negedge i_clk); while (angle_q.size() != 0);
            end
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
        while (angle_q.size() != 0) @(negedge i_clk);
        settle = 0;
        while (settle < 2 * Latency) begin
            @(negedge i_clk);
            settle++;
        end
        if (errors == 0) begin
            $display("** fixed_atan2_octant_polynomial_top: PASSED **");
        end else begin
            $display("** fixed_atan2_octant_polynomial_top: FAILED **");
        end
        $finish;
    end
endmodule

@@ files.f @@
design/fap_pkg.sv
design/fap_fold.sv
design/fap_div.sv
design/fap_poly.sv
design/fixed_atan2_octant_polynomial_top.sv
tb/fixed_atan2_octant_polynomial_top_tb.sv
